// File: rtl/cgva_pkg.sv
// ----------------------------------------------------------------------------
// cgva_pkg
// Shared types, constants and functions of the camera point to galvo angle
// solver: request and result structs, fixed-point widths, arctangent table.
// ----------------------------------------------------------------------------
package cgva_pkg;

	localparam int CORDIC_STAGES_DEF = 16;
	localparam int CW = 34;
	localparam int AW = 34;
	localparam int OUT_W = 16;
	localparam logic [31:0] GAIN_Q32 = 32'h9B74EDA8;
	localparam int QUARTER_TURN = 23040;
	localparam int HALF_TURN = 46080;
	localparam int FULL_TURN = 92160;

	typedef logic signed [CW-1:0] coord_t;
	typedef logic signed [AW-1:0] angle_t;

	typedef enum logic [2:0] {
		REG_OFFSET_X = 3'd0,
		REG_OFFSET_Y = 3'd1,
		REG_OFFSET_Z = 3'd2,
		REG_TURN_A   = 3'd3,
		REG_TURN_B   = 3'd4,
		REG_TURN_C   = 3'd5,
		REG_GAP      = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic signed [19:0] point_x;
		logic signed [19:0] point_y;
		logic signed [19:0] point_z;
	} point_t;

	typedef struct packed {
		logic signed [15:0] optical_x_angle;
		logic signed [15:0] optical_y_angle;
		logic               angles_valid;
	} result_t;

	typedef struct packed {
		logic   flip;
		angle_t ang;
	} turn_t;

	function automatic int latency(input int n);
		return 5 * n + 11;
	endfunction

	function automatic angle_t atan_val(input int i);
		logic [29:0] v;
		case (i)
			0: v = 30'd754974720;
			1: v = 30'd445687602;
			2: v = 30'd235489089;
			3: v = 30'd119537938;
			4: v = 30'd60000934;
			5: v = 30'd30029717;
			6: v = 30'd15018523;
			7: v = 30'd7509720;
			8: v = 30'd3754917;
			9: v = 30'd1877466;
			10: v = 30'd938734;
			11: v = 30'd469367;
			12: v = 30'd234684;
			13: v = 30'd117342;
			14: v = 30'd58671;
			15: v = 30'd29335;
			16: v = 30'd14668;
			17: v = 30'd7334;
			18: v = 30'd3667;
			19: v = 30'd1833;
			20: v = 30'd917;
			21: v = 30'd458;
			22: v = 30'd229;
			23: v = 30'd115;
			24: v = 30'd57;
			25: v = 30'd29;
			26: v = 30'd14;
			27: v = 30'd7;
			28: v = 30'd4;
			29: v = 30'd2;
			30: v = 30'd1;
			default: v = 30'd0;
		endcase
		return angle_t'({4'd0, v});
	endfunction

	// negate, wrap to (-180, 180], fold into +-90 with a half-turn flip
	function automatic turn_t prep_turn(input logic signed [16:0] t);
		logic signed [18:0] a;
		turn_t r;
		a = -{{2{t[16]}}, t};
		if (a > 19'sd46080)
			a = a - 19'sd92160;
		else if (a <= -19'sd46080)
			a = a + 19'sd92160;
		r.flip = 1'b0;
		if (a > 19'sd23040) begin
			r.flip = 1'b1;
			a = a - 19'sd46080;
		end else if (a < -19'sd23040) begin
			r.flip = 1'b1;
			a = a + 19'sd46080;
		end
		r.ang = angle_t'(a) <<< 16;
		return r;
	endfunction

	function automatic logic signed [OUT_W-1:0] to_output(input angle_t z);
		angle_t r;
		r = (z + angle_t'(32768)) >>> 16;
		if (r > angle_t'(QUARTER_TURN))
			r = angle_t'(QUARTER_TURN);
		if (r < -angle_t'(QUARTER_TURN))
			r = -angle_t'(QUARTER_TURN);
		return r[OUT_W-1:0];
	endfunction

endpackage

// File: rtl/camera_point_to_galvo_angles.sv
// ----------------------------------------------------------------------------
// camera_point_to_galvo_angles
// Maps a camera-frame point to the two optical angles of a two-mirror galvo.
// ----------------------------------------------------------------------------
// usage
//   request: pulse start with point; busy is always low, so a new point may
//   be given in every cycle
//   result: done is high for one cycle with result; every request gives one
//   result, with angles_valid low and zero angles when the point lies behind
//   the camera or behind the galvo
//   pipeline: three rotation pipelines of CORDIC_STAGES + 2 stages and two
//   vectoring pipelines of CORDIC_STAGES + 1 stages
//   throughput: one point per cycle
//   configuration: cfg_we / cfg_idx / cfg_wdata, write only while idle;
//   unknown indexes are ignored
//   reset: configuration and valid registers clear to zero, pipeline emptied, no done pulse
//   the receiver cannot stall; results are shown for exactly one cycle
// ----------------------------------------------------------------------------
module camera_point_to_galvo_angles #(
	parameter int CORDIC_STAGES = cgva_pkg::CORDIC_STAGES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  cgva_pkg::point_t  point,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_idx,
	input  logic [19:0]       cfg_wdata,
	output logic              done,
	output cgva_pkg::result_t result
);

	localparam int CW = cgva_pkg::CW;
	localparam int AW = cgva_pkg::AW;

	logic signed [19:0] offset_x_q, offset_y_q, offset_z_q;
	logic signed [16:0] turn_a_q, turn_b_q, turn_c_q;
	logic [13:0]        gap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_x_q <= '0;
			offset_y_q <= '0;
			offset_z_q <= '0;
			turn_a_q <= '0;
			turn_b_q <= '0;
			turn_c_q <= '0;
			gap_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				cgva_pkg::REG_OFFSET_X: offset_x_q <= cfg_wdata;
				cgva_pkg::REG_OFFSET_Y: offset_y_q <= cfg_wdata;
				cgva_pkg::REG_OFFSET_Z: offset_z_q <= cfg_wdata;
				cgva_pkg::REG_TURN_A:   turn_a_q <= cfg_wdata[16:0];
				cgva_pkg::REG_TURN_B:   turn_b_q <= cfg_wdata[16:0];
				cgva_pkg::REG_TURN_C:   turn_c_q <= cfg_wdata[16:0];
				cgva_pkg::REG_GAP:      gap_q <= cfg_wdata[13:0];
				default: ;
			endcase
		end
	end

	cgva_pkg::turn_t turn_a, turn_b, turn_c;
	assign turn_a = cgva_pkg::prep_turn(turn_a_q);
	assign turn_b = cgva_pkg::prep_turn(turn_b_q);
	assign turn_c = cgva_pkg::prep_turn(turn_c_q);

	assign busy = 1'b0;

	// offset removal and scaling to 1/4096 mm
	logic             v_s1, ok_s1;
	cgva_pkg::coord_t x_s1, y_s1, z_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		ok_s1 <= point.point_z > 20'sd0;
		x_s1 <= (CW'(point.point_x) - CW'(offset_x_q)) <<< 8;
		y_s1 <= (CW'(point.point_y) - CW'(offset_y_q)) <<< 8;
		z_s1 <= (CW'(point.point_z) - CW'(offset_z_q)) <<< 8;
	end

	// rotation about x: (y, z)
	logic             v_rx;
	cgva_pkg::coord_t y_rx, z_rx;
	logic [CW:0]      side_rx;

	cgva_rot #(.STAGES(CORDIC_STAGES), .SW(CW + 1)) u_rot_x (
		.clk(clk), .arst_n(arst_n),
		.in_valid(v_s1), .in_a(y_s1), .in_b(z_s1), .turn(turn_b),
		.in_side({ok_s1, x_s1}),
		.out_valid(v_rx), .out_a(y_rx), .out_b(z_rx), .out_side(side_rx)
	);

	// rotation about y: (z, x)
	logic             v_ry;
	cgva_pkg::coord_t z_ry, x_ry;
	logic [CW:0]      side_ry;

	cgva_rot #(.STAGES(CORDIC_STAGES), .SW(CW + 1)) u_rot_y (
		.clk(clk), .arst_n(arst_n),
		.in_valid(v_rx), .in_a(z_rx), .in_b(side_rx[CW-1:0]), .turn(turn_a),
		.in_side({side_rx[CW], y_rx}),
		.out_valid(v_ry), .out_a(z_ry), .out_b(x_ry), .out_side(side_ry)
	);

	// rotation about z: (x, y)
	logic             v_rz;
	cgva_pkg::coord_t x_rz, y_rz;
	logic [CW:0]      side_rz;

	cgva_rot #(.STAGES(CORDIC_STAGES), .SW(CW + 1)) u_rot_z (
		.clk(clk), .arst_n(arst_n),
		.in_valid(v_ry), .in_a(x_ry), .in_b(side_ry[CW-1:0]), .turn(turn_c),
		.in_side({side_ry[CW], z_ry}),
		.out_valid(v_rz), .out_a(x_rz), .out_b(y_rz), .out_side(side_rz)
	);

	// galvo-side depth check and mirror gap
	logic             v_s2, ok_s2;
	cgva_pkg::coord_t x_s2, y_s2, zeff_s2;
	cgva_pkg::coord_t z_rz;
	assign z_rz = side_rz[CW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_rz;
		end
	end

	always_ff @(posedge clk) begin
		ok_s2 <= side_rz[CW] && (z_rz > 0);
		x_s2 <= x_rz;
		y_s2 <= y_rz;
		zeff_s2 <= z_rz + (CW'(gap_q) <<< 8);
	end

	// y angle and length in the y-z plane
	logic             v_v1;
	cgva_pkg::coord_t r_v1;
	cgva_pkg::angle_t ay_v1;
	logic [CW:0]      side_v1;

	cgva_vec #(.STAGES(CORDIC_STAGES), .SW(CW + 1)) u_vec_y (
		.clk(clk), .arst_n(arst_n),
		.in_valid(v_s2), .in_x(zeff_s2), .in_y(y_s2), .in_side({ok_s2, x_s2}),
		.out_valid(v_v1), .mag(r_v1), .angle(ay_v1), .out_side(side_v1)
	);

	// x angle
	logic             v_v2;
	cgva_pkg::angle_t ax_v2;
	logic [AW:0]      side_v2;

	cgva_vec #(.STAGES(CORDIC_STAGES), .SW(AW + 1)) u_vec_x (
		.clk(clk), .arst_n(arst_n),
		.in_valid(v_v1), .in_x(r_v1), .in_y(side_v1[CW-1:0]),
		.in_side({side_v1[CW], ay_v1}),
		.out_valid(v_v2), .mag(), .angle(ax_v2), .out_side(side_v2)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= v_v2;
		end
	end

	always_ff @(posedge clk) begin
		result.angles_valid <= side_v2[AW];
		result.optical_x_angle <= side_v2[AW] ? cgva_pkg::to_output(ax_v2) : '0;
		result.optical_y_angle <= side_v2[AW] ?
			cgva_pkg::to_output(side_v2[AW-1:0]) : '0;
	end

endmodule

// File: rtl/cgva_rot.sv
// ----------------------------------------------------------------------------
// cgva_rot
// Pipelined rotation CORDIC: quarter-turn fold, one micro-rotation per
// stage, then a registered gain correction. A side vector rides along.
// ----------------------------------------------------------------------------
module cgva_rot #(
	parameter int STAGES = cgva_pkg::CORDIC_STAGES_DEF,
	parameter int SW = 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  cgva_pkg::coord_t      in_a,
	input  cgva_pkg::coord_t      in_b,
	input  cgva_pkg::turn_t       turn,
	input  logic [SW-1:0]         in_side,
	output logic                  out_valid,
	output cgva_pkg::coord_t      out_a,
	output cgva_pkg::coord_t      out_b,
	output logic [SW-1:0]         out_side
);

	localparam int CW = cgva_pkg::CW;
	localparam logic signed [CW-1:0] GAIN_S = CW'(cgva_pkg::GAIN_Q32);

	cgva_pkg::coord_t a_s [0:STAGES];
	cgva_pkg::coord_t b_s [0:STAGES];
	cgva_pkg::angle_t z_s [0:STAGES];
	logic [SW-1:0]    side_s [0:STAGES];
	logic             v_s [0:STAGES];

	// entry stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		a_s[0] <= turn.flip ? -in_a : in_a;
		b_s[0] <= turn.flip ? -in_b : in_b;
		z_s[0] <= turn.ang;
		side_s[0] <= in_side;
	end

	for (genvar i = 0; i < STAGES; i++) begin : g_iter
		cgva_pkg::coord_t da;
		cgva_pkg::coord_t db;
		assign da = b_s[i] >>> i;
		assign db = a_s[i] >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			side_s[i+1] <= side_s[i];
			if (z_s[i] >= 0) begin
				a_s[i+1] <= a_s[i] - da;
				b_s[i+1] <= b_s[i] + db;
				z_s[i+1] <= z_s[i] - cgva_pkg::atan_val(i);
			end else begin
				a_s[i+1] <= a_s[i] + da;
				b_s[i+1] <= b_s[i] - db;
				z_s[i+1] <= z_s[i] + cgva_pkg::atan_val(i);
			end
		end
	end

	// gain correction
	logic signed [2*CW-1:0] prod_a;
	logic signed [2*CW-1:0] prod_b;
	assign prod_a = a_s[STAGES] * GAIN_S;
	assign prod_b = b_s[STAGES] * GAIN_S;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= v_s[STAGES];
		end
	end

	always_ff @(posedge clk) begin
		out_a <= prod_a[CW+31:32];
		out_b <= prod_b[CW+31:32];
		out_side <= side_s[STAGES];
	end

endmodule

// File: rtl/cgva_vec.sv
// ----------------------------------------------------------------------------
// cgva_vec
// Pipelined vectoring CORDIC: drives y to zero one stage at a time,
// accumulating the angle, then a registered gain correction of the length.
// ----------------------------------------------------------------------------
module cgva_vec #(
	parameter int STAGES = cgva_pkg::CORDIC_STAGES_DEF,
	parameter int SW = 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  cgva_pkg::coord_t      in_x,
	input  cgva_pkg::coord_t      in_y,
	input  logic [SW-1:0]         in_side,
	output logic                  out_valid,
	output cgva_pkg::coord_t      mag,
	output cgva_pkg::angle_t      angle,
	output logic [SW-1:0]         out_side
);

	localparam int CW = cgva_pkg::CW;
	localparam logic signed [CW-1:0] GAIN_S = CW'(cgva_pkg::GAIN_Q32);

	cgva_pkg::coord_t x_s [0:STAGES];
	cgva_pkg::coord_t y_s [0:STAGES];
	cgva_pkg::angle_t z_s [0:STAGES];
	logic [SW-1:0]    side_s [0:STAGES];
	logic             v_s [0:STAGES];

	assign x_s[0] = in_x;
	assign y_s[0] = in_y;
	assign z_s[0] = '0;
	assign side_s[0] = in_side;
	assign v_s[0] = in_valid;

	for (genvar i = 0; i < STAGES; i++) begin : g_iter
		cgva_pkg::coord_t dx;
		cgva_pkg::coord_t dy;
		assign dx = y_s[i] >>> i;
		assign dy = x_s[i] >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			side_s[i+1] <= side_s[i];
			if (y_s[i] > 0) begin
				x_s[i+1] <= x_s[i] + dx;
				y_s[i+1] <= y_s[i] - dy;
				z_s[i+1] <= z_s[i] + cgva_pkg::atan_val(i);
			end else begin
				x_s[i+1] <= x_s[i] - dx;
				y_s[i+1] <= y_s[i] + dy;
				z_s[i+1] <= z_s[i] - cgva_pkg::atan_val(i);
			end
		end
	end

	logic signed [2*CW-1:0] prod_x;
	assign prod_x = x_s[STAGES] * GAIN_S;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= v_s[STAGES];
		end
	end

	always_ff @(posedge clk) begin
		mag <= prod_x[CW+31:32];
		angle <= z_s[STAGES];
		out_side <= side_s[STAGES];
	end

endmodule

// File: rtl/cgva_checker.sv
// ----------------------------------------------------------------------------
// cgva_checker
// Port-level checks of the galvo angle solver, bound to the top level.
// ----------------------------------------------------------------------------
module cgva_checker #(
	parameter int STAGES = cgva_pkg::CORDIC_STAGES_DEF
) (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input cgva_pkg::result_t result
);

	localparam int LAT = cgva_pkg::latency(STAGES);

	a_done_has_request: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without request");

	a_request_gives_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("request lost");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.angles_valid) |->
			(result.optical_x_angle == 16'sd0 && result.optical_y_angle == 16'sd0))
		else $error("invalid result with nonzero angles");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.optical_x_angle <= 16'sd23040
			&& result.optical_x_angle >= -16'sd23040
			&& result.optical_y_angle <= 16'sd23040
			&& result.optical_y_angle >= -16'sd23040))
		else $error("angle out of range");

endmodule

bind camera_point_to_galvo_angles cgva_checker #(.STAGES(CORDIC_STAGES)) u_cgva_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
	.done(done), .result(result)
);

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the camera point to galvo angle solver against a predictor built
// from the fixed-point CORDIC arithmetic. Runs several register settings,
// including the extremes, with directed edge points and random points, and
// with random gaps in the request stream.
// ----------------------------------------------------------------------------
module tb_top;

	localparam logic [2:0] REG_UNUSED = 3'd7;
	localparam int NUM_PHASES = 9;
	localparam int RAND_PER_PHASE = 205;
	localparam int CYCLE_LIMIT = 300000;
	localparam int DRAIN_CYCLES = 5 * cgva_pkg::CORDIC_STAGES_DEF + 11 + 20;
	localparam longint GAIN = 64'sd2608131496;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	cgva_pkg::point_t point;
	logic cfg_we;
	logic [2:0] cfg_idx;
	logic [19:0] cfg_wdata;
	logic done;
	cgva_pkg::result_t result;

	longint off_x, off_y, off_z, turn_a, turn_b, turn_c, gap;
	cgva_pkg::point_t pend_q[$];
	cgva_pkg::result_t angles_q[$];
	int errors;
	int cycles;
	int idle_pct;
	logic took_last;

	camera_point_to_galvo_angles dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.point(point),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata),
		.done(done),
		.result(result)
	);

	function automatic longint atan_step(input int i);
		longint tab[32];
		tab = '{754974720, 445687602, 235489089, 119537938, 60000934, 30029717,
			15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684, 117342,
			58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29,
			14, 7, 4, 2, 1, 0};
		return tab[i];
	endfunction

	function automatic void spin_pair(inout longint a, inout longint b, input longint ang);
		longint x, y, z, dx, dy;
		x = a;
		y = b;
		while (ang > cgva_pkg::HALF_TURN) ang -= cgva_pkg::FULL_TURN;
		while (ang <= -cgva_pkg::HALF_TURN) ang += cgva_pkg::FULL_TURN;
		if (ang > cgva_pkg::QUARTER_TURN) begin
			x = -x; y = -y; ang -= cgva_pkg::HALF_TURN;
		end else if (ang < -cgva_pkg::QUARTER_TURN) begin
			x = -x; y = -y; ang += cgva_pkg::HALF_TURN;
		end
		z = ang * 65536;
		for (int i = 0; i < cgva_pkg::CORDIC_STAGES_DEF; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= atan_step(i);
			end else begin
				x += dx; y -= dy; z += atan_step(i);
			end
		end
		a = (x * GAIN) >>> 32;
		b = (y * GAIN) >>> 32;
	endfunction

	function automatic longint vector_atan(input longint x, input longint y, output longint mag);
		longint z, dx, dy;
		z = 0;
		for (int i = 0; i < cgva_pkg::CORDIC_STAGES_DEF; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y > 0) begin
				x += dx; y -= dy; z += atan_step(i);
			end else begin
				x -= dx; y += dy; z -= atan_step(i);
			end
		end
		mag = (x * GAIN) >>> 32;
		return z;
	endfunction

	function automatic logic signed [15:0] round_deg(input longint z);
		longint r;
		r = (z + 32768) >>> 16;
		if (r > cgva_pkg::QUARTER_TURN) r = cgva_pkg::QUARTER_TURN;
		if (r < -cgva_pkg::QUARTER_TURN) r = -cgva_pkg::QUARTER_TURN;
		return r[15:0];
	endfunction

	function automatic cgva_pkg::result_t galvo_angles(input cgva_pkg::point_t p);
		cgva_pkg::result_t r;
		longint x, y, z, zeff, hyp, mag, ax, ay;
		r = '0;
		if (p.point_z <= 0) return r;
		x = (longint'(p.point_x) - off_x) * 256;
		y = (longint'(p.point_y) - off_y) * 256;
		z = (longint'(p.point_z) - off_z) * 256;
		spin_pair(y, z, -turn_b);
		spin_pair(z, x, -turn_a);
		spin_pair(x, y, -turn_c);
		if (z <= 0) return r;
		zeff = z + gap * 256;
		ay = vector_atan(zeff, y, hyp);
		ax = vector_atan(hyp, x, mag);
		r.optical_x_angle = round_deg(ax);
		r.optical_y_angle = round_deg(ay);
		r.angles_valid = 1'b1;
		return r;
	endfunction

	task automatic report(input string what, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
		errors++;
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [19:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= v;
		case (idx)
			cgva_pkg::REG_OFFSET_X: off_x = longint'($signed(v));
			cgva_pkg::REG_OFFSET_Y: off_y = longint'($signed(v));
			cgva_pkg::REG_OFFSET_Z: off_z = longint'($signed(v));
			cgva_pkg::REG_TURN_A: turn_a = longint'($signed(v[16:0]));
			cgva_pkg::REG_TURN_B: turn_b = longint'($signed(v[16:0]));
			cgva_pkg::REG_TURN_C: turn_c = longint'($signed(v[16:0]));
			cgva_pkg::REG_GAP: gap = longint'(v[13:0]);
			default: ;
		endcase
	endtask

	task automatic add_point(input int x, input int y, input int z);
		cgva_pkg::point_t p;
		p.point_x = x[19:0];
		p.point_y = y[19:0];
		p.point_z = z[19:0];
		pend_q.push_back(p);
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// request driver
	always @(negedge clk) begin
		cgva_pkg::point_t nxt;
		if (!start || took_last) begin
			if (pend_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
				nxt = pend_q.pop_front();
				start <= 1'b1;
				point <= nxt;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		cgva_pkg::result_t want;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end else begin
			took_last = start && !busy && arst_n;
			if (took_last) angles_q.push_back(galvo_angles(point));
			if (done) begin
				if (angles_q.size() == 0) begin
					report("unexpected result", result.angles_valid, 0);
				end else begin
					want = angles_q.pop_front();
					if (result.optical_x_angle !== want.optical_x_angle)
						report("optical_x_angle", result.optical_x_angle, want.optical_x_angle);
					if (result.optical_y_angle !== want.optical_y_angle)
						report("optical_y_angle", result.optical_y_angle, want.optical_y_angle);
					if (result.angles_valid !== want.angles_valid)
						report("angles_valid", result.angles_valid, want.angles_valid);
				end
			end
		end
	end

	initial begin
		logic [19:0] regs[7];
		arst_n = 1'b0;
		start = 1'b0;
		point = '0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_wdata = '0;
		off_x = 0; off_y = 0; off_z = 0;
		turn_a = 0; turn_b = 0; turn_c = 0; gap = 0;
		errors = 0;
		cycles = 0;
		idle_pct = 0;
		took_last = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				0: regs = '{0, 0, 0, 0, 0, 0, 0};
				1: regs = '{20'h80000, 20'h80000, 20'h80000, 20'h10000, 20'h0FFFF,
					20'd46080, 20'd16383};
				2: regs = '{20'h7FFFF, 20'h7FFFF, 20'h7FFFF, -20'sd46080, 20'd46080,
					-20'sd46080, 0};
				3: regs = '{0, 0, 0, 20'd23040, -20'sd23040, 20'd23041, 20'd100};
				default: begin
					for (int k = 0; k < 3; k++)
						regs[k] = ($urandom_range(3) == 0) ? 20'($urandom())
							: 20'($signed(20'($urandom_range(40000))) - 20000);
					for (int k = 3; k < 6; k++)
						regs[k] = ($urandom_range(1) == 0) ? 20'($urandom_range(131071))
							: 20'($signed(20'($urandom_range(6000))) - 3000);
					regs[6] = 20'($urandom_range(16383));
				end
			endcase
			for (int k = 0; k < 7; k++) write_reg(k[2:0], regs[k]);
			if (ph == 1) write_reg(REG_UNUSED, 20'hFFFFF);
			@(negedge clk);
			cfg_we <= 1'b0;
			idle_pct = (ph % 3 == 0) ? 17 : (ph % 3 == 1) ? 77 : 0;
			if (ph < 3) begin
				add_point(0, 0, 1);
				add_point(0, 0, 0);
				add_point(0, 0, -1);
				add_point(0, 0, -524288);
				add_point(524287, 524287, 524287);
				add_point(-524288, -524288, 524287);
				add_point(524287, -524288, 1);
				add_point(-524288, 524287, 1);
				add_point(1, 0, 1);
				add_point(0, -1, 1);
				add_point(-1, -1, 524287);
				add_point(300000, -300000, 2000);
			end
			for (int n = 0; n < RAND_PER_PHASE; n++) begin
				if ($urandom_range(4) == 0)
					add_point($urandom(), $urandom(), $urandom());
				else if ($urandom_range(1) == 0)
					add_point($urandom(), $urandom(), $urandom_range(524287, 1));
				else
					add_point(int'($urandom_range(8000)) - 4000,
						int'($urandom_range(8000)) - 4000, $urandom_range(60000, 1));
			end
			while (pend_q.size() > 0 || start || angles_q.size() > 0) @(posedge clk);
			repeat (DRAIN_CYCLES) @(posedge clk);
		end
		if (errors == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

// File: filelist.f
rtl/cgva_pkg.sv
rtl/cgva_rot.sv
rtl/cgva_vec.sv
rtl/camera_point_to_galvo_angles.sv
rtl/cgva_checker.sv
sim/tb_top.sv
